### rtl/core/gdod_pkg.sv
`default_nettype none

package gdod_pkg;

	// defaults for the top level parameters
	localparam int LAST_YEAR_DEF   = 9999;
	localparam int OFFSET_BITS_DEF = 21;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// field widths
	localparam int YEAR_W       = 14;
	localparam int MONTH_W      = 4;
	localparam int DAY_W        = 5;
	localparam int DIFF_W       = 23;
	localparam int OFFSET_MAX_W = 32;
	localparam int YEAR_MAX_W   = 16;
	localparam int CUM_W        = 9;

	// y / 100 == (y * DIV100_MUL) >> DIV100_SHIFT for y below 91180
	localparam int DIV100_MUL   = 83887;
	localparam int DIV100_SHIFT = 23;

	localparam int MONTHS = 12;

	// command codes
	localparam logic CMD_SHIFT = 1'b0;
	localparam logic CMD_DIFF  = 1'b1;

	// one classified word, front to back
	typedef struct packed {
		logic                           cmd;
		logic                           err;
		logic                           leap_f;
		logic                           leap_s;
		logic [YEAR_W-1:0]              fy;
		logic [MONTH_W-1:0]             fm;
		logic [DAY_W-1:0]               fd;
		logic [YEAR_W-1:0]              sy;
		logic [MONTH_W-1:0]             sm;
		logic [DAY_W-1:0]               sd;
		logic signed [OFFSET_MAX_W-1:0] off;
	} entry_t;

	// length of month m, zero for a month code that means nothing
	function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
		logic [DAY_W-1:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = leap ? 5'd29 : 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

	// gregorian leap rule, q is y / 100
	function automatic logic is_leap(logic [YEAR_MAX_W-1:0] y, logic [YEAR_MAX_W-1:0] q);
		logic [YEAR_MAX_W-1:0] hund;
		hund = YEAR_MAX_W'(32'(q) * 32'(100));
		return (y[1:0] == 2'b00) && ((y != hund) || (y[3:0] == 4'b0000));
	endfunction

endpackage

`default_nettype wire

### rtl/core/gdod_ifs.sv
`default_nettype none

// input channel: one date command per word
interface gdod_item_if #(parameter int OFFSET_BITS = gdod_pkg::OFFSET_BITS_DEF);
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [gdod_pkg::YEAR_W-1:0]         first_year;
	logic [gdod_pkg::MONTH_W-1:0]        first_month;
	logic [gdod_pkg::DAY_W-1:0]          first_day;
	logic signed [OFFSET_BITS-1:0]       offset_days;
	logic [gdod_pkg::YEAR_W-1:0]         second_year;
	logic [gdod_pkg::MONTH_W-1:0]        second_month;
	logic [gdod_pkg::DAY_W-1:0]          second_day;

	modport source (
		output valid, command, first_year, first_month, first_day, offset_days,
		output second_year, second_month, second_day,
		input  ready
	);
	modport sink (
		input  valid, command, first_year, first_month, first_day, offset_days,
		input  second_year, second_month, second_day,
		output ready
	);
endinterface

// result channel: one result word per command
interface gdod_result_if;
	logic                                valid;
	logic                                ready;
	logic [gdod_pkg::YEAR_W-1:0]         result_year;
	logic [gdod_pkg::MONTH_W-1:0]        result_month;
	logic [gdod_pkg::DAY_W-1:0]          result_day;
	logic signed [gdod_pkg::DIFF_W-1:0]  day_difference;
	logic                                first_later;
	logic                                dates_equal;
	logic                                error;

	modport source (
		output valid, result_year, result_month, result_day, day_difference,
		output first_later, dates_equal, error,
		input  ready
	);
	modport sink (
		input  valid, result_year, result_month, result_day, day_difference,
		input  first_later, dates_equal, error,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/gdod_front.sv
`default_nettype none

module gdod_front #(
	parameter int LAST_YEAR = gdod_pkg::LAST_YEAR_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	gdod_item_if.sink             item,
	output gdod_pkg::entry_t      push_data,
	output logic                  push,
	input  wire logic             full
);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_PUSH} state_t;

	state_t                              st_q;
	logic                                cmd_q;
	logic [gdod_pkg::YEAR_W-1:0]         fy_q, sy_q;
	logic [gdod_pkg::MONTH_W-1:0]        fm_q, sm_q;
	logic [gdod_pkg::DAY_W-1:0]          fd_q, sd_q;
	logic signed [gdod_pkg::OFFSET_MAX_W-1:0] off_q;
	logic [gdod_pkg::YEAR_W-1:0]         fq_q, sq_q;
	logic                                leap_f, leap_s, ok_f, ok_s;

	// range and month length check of one date
	function automatic logic date_ok(logic [gdod_pkg::YEAR_W-1:0] y, logic leap,
			logic [gdod_pkg::MONTH_W-1:0] m, logic [gdod_pkg::DAY_W-1:0] d);
		logic y_ok;
		y_ok = (y != '0) && (32'(y) <= 32'(LAST_YEAR));
		return y_ok && (m >= 4'd1) && (m <= 4'(gdod_pkg::MONTHS)) && (d != '0)
			&& (d <= gdod_pkg::month_len(m, leap));
	endfunction

	// leap flags and validity from the registered year quotients
	always_comb begin
		leap_f = gdod_pkg::is_leap(gdod_pkg::YEAR_MAX_W'(fy_q), gdod_pkg::YEAR_MAX_W'(fq_q));
		leap_s = gdod_pkg::is_leap(gdod_pkg::YEAR_MAX_W'(sy_q), gdod_pkg::YEAR_MAX_W'(sq_q));
		ok_f   = date_ok(fy_q, leap_f, fm_q, fd_q);
		ok_s   = date_ok(sy_q, leap_s, sm_q, sd_q);
	end

	// classified word towards the queue
	always_comb begin
		push_data.cmd    = cmd_q;
		push_data.err    = (cmd_q == gdod_pkg::CMD_DIFF) ? !(ok_f && ok_s) : !ok_f;
		push_data.leap_f = leap_f;
		push_data.leap_s = leap_s;
		push_data.fy     = fy_q;
		push_data.fm     = fm_q;
		push_data.fd     = fd_q;
		push_data.sy     = sy_q;
		push_data.sm     = sm_q;
		push_data.sd     = sd_q;
		push_data.off    = off_q;
	end

	assign push       = (st_q == ST_PUSH) && !full;
	assign item.ready = (st_q == ST_IDLE);

	// capture, divide years by 100, hand over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cmd_q <= 1'b0;
			fy_q  <= '0;
			fm_q  <= '0;
			fd_q  <= '0;
			sy_q  <= '0;
			sm_q  <= '0;
			sd_q  <= '0;
			off_q <= '0;
			fq_q  <= '0;
			sq_q  <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (item.valid) begin
						cmd_q <= item.command;
						fy_q  <= item.first_year;
						fm_q  <= item.first_month;
						fd_q  <= item.first_day;
						sy_q  <= item.second_year;
						sm_q  <= item.second_month;
						sd_q  <= item.second_day;
						off_q <= gdod_pkg::OFFSET_MAX_W'(item.offset_days);
						st_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					fq_q <= gdod_pkg::YEAR_W'((32'(fy_q) * 32'(gdod_pkg::DIV100_MUL))
						>> gdod_pkg::DIV100_SHIFT);
					sq_q <= gdod_pkg::YEAR_W'((32'(sy_q) * 32'(gdod_pkg::DIV100_MUL))
						>> gdod_pkg::DIV100_SHIFT);
					st_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!full) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/gdod_queue.sv
`default_nettype none

module gdod_queue #(
	parameter int DEPTH = gdod_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  gdod_pkg::entry_t       push_data,
	output logic                   full,
	input  wire logic              pop,
	output gdod_pkg::entry_t       pop_data,
	output logic                   avail
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gdod_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign avail    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// the front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");

	// the back never takes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> avail)
		else $error("queue read while empty");

	// an empty queue has equal pointers
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

### rtl/core/gdod_back.sv
`default_nettype none

module gdod_back #(
	parameter int LAST_YEAR   = gdod_pkg::LAST_YEAR_DEF,
	parameter int OFFSET_BITS = gdod_pkg::OFFSET_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          avail,
	input  gdod_pkg::entry_t   pop_data,
	output logic               pop,
	gdod_result_if.source      result
);

	// day number helper, evaluated at elaboration only
	function automatic longint days_before_year(longint y);
		longint p;
		p = y - 1;
		return p * 365 + p / 4 - p / 100 + p / 400;
	endfunction

	// days in the months before m
	function automatic logic [gdod_pkg::CUM_W-1:0] days_before_month(
			logic [gdod_pkg::MONTH_W-1:0] m, logic leap);
		logic [gdod_pkg::CUM_W-1:0] c;
		unique case (m)
			4'd1:    c = 9'd0;
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		if (leap && (m > 4'd2)) begin
			c = c + 9'd1;
		end
		return c;
	endfunction

	localparam int     YW     = $clog2(LAST_YEAR + 1);
	localparam int     SELW   = (YW > 1) ? $clog2(YW) : 1;
	localparam int     DW     = YW + 9;
	localparam int     SW     = ((DW > OFFSET_BITS) ? DW : OFFSET_BITS) + 2;
	localparam int     MULW   = YW + gdod_pkg::DIV100_SHIFT;
	localparam longint DBY_END = days_before_year(longint'(LAST_YEAR) + 1);
	localparam logic signed [SW-1:0] DIFF_HI = SW'(2 ** (gdod_pkg::DIFF_W - 1) - 1);
	localparam logic signed [SW-1:0] DIFF_LO = SW'(-(2 ** (gdod_pkg::DIFF_W - 1)));

	typedef enum logic [3:0] {
		ST_IDLE, ST_WAIT, ST_SERA, ST_SERB, ST_DIFF, ST_ADD, ST_RNG,
		ST_BCMP, ST_LEAP, ST_MW, ST_OUT
	} state_t;

	state_t                               st_q, ret_q;
	logic                                 wcnt_q;
	gdod_pkg::entry_t                     ent_q;

	// shared day-number pipeline
	logic [YW-1:0]                        dby_p_q;
	logic [DW-1:0]                        p365_s1;
	logic [YW-1:0]                        q100_s1, pd_s1;
	logic [MULW-1:0]                      q100_prod;
	logic [DW-1:0]                        dby_s2;

	logic [DW-1:0]                        ser_a_q, ser_b_q, base_q;
	logic signed [SW-1:0]                 n_q;
	logic [YW-1:0]                        yr_q;
	logic [SELW-1:0]                      sel_q;
	logic                                 leap_q;
	logic [gdod_pkg::CUM_W-1:0]           r_q;
	logic [gdod_pkg::MONTH_W-1:0]         mo_q;

	// staged result
	logic [gdod_pkg::YEAR_W-1:0]          ry_q;
	logic [gdod_pkg::MONTH_W-1:0]         rm_q;
	logic [gdod_pkg::DAY_W-1:0]           rd_q;
	logic signed [gdod_pkg::DIFF_W-1:0]   diff_q;
	logic                                 later_q, equal_q, err_q;

	// output register
	logic                                 out_valid_q;
	logic [gdod_pkg::YEAR_W-1:0]          out_year_q;
	logic [gdod_pkg::MONTH_W-1:0]         out_month_q;
	logic [gdod_pkg::DAY_W-1:0]           out_day_q;
	logic signed [gdod_pkg::DIFF_W-1:0]   out_diff_q;
	logic                                 out_later_q, out_equal_q, out_err_q;

	logic [DW-1:0]                        ser_f, ser_s;
	logic signed [SW-1:0]                 diff_w;
	logic [YW-1:0]                        cand, new_yr, next_cand;
	logic                                 take;
	logic [gdod_pkg::DAY_W-1:0]           dim;
	logic                                 out_free;

	// days before January 1 of p + 1, two stages behind dby_p_q
	assign q100_prod = MULW'(dby_p_q) * MULW'(gdod_pkg::DIV100_MUL);

	always_ff @(posedge clk) begin
		p365_s1 <= DW'(dby_p_q) * DW'(365);
		q100_s1 <= q100_prod[gdod_pkg::DIV100_SHIFT +: YW];
		pd_s1   <= dby_p_q;
		dby_s2  <= p365_s1 + DW'(pd_s1 >> 2) - DW'(q100_s1) + DW'(q100_s1 >> 2);
	end

	// serial day numbers of the two dates
	always_comb begin
		ser_f  = dby_s2 + DW'(days_before_month(ent_q.fm, ent_q.leap_f)) + DW'(ent_q.fd)
			- DW'(1);
		ser_s  = dby_s2 + DW'(days_before_month(ent_q.sm, ent_q.leap_s)) + DW'(ent_q.sd)
			- DW'(1);
		diff_w = $signed(SW'(ser_a_q)) - $signed(SW'(ser_b_q));
	end

	// one step of the bitwise year search
	always_comb begin
		cand      = yr_q | (YW'(1) << sel_q);
		take      = (dby_s2 <= n_q[DW-1:0]);
		new_yr    = take ? cand : yr_q;
		next_cand = new_yr | (YW'(1) << (sel_q - SELW'(1)));
		dim       = gdod_pkg::month_len(mo_q, leap_q);
	end

	assign pop      = (st_q == ST_IDLE) && avail;
	assign out_free = !out_valid_q || result.ready;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ret_q       <= ST_IDLE;
			wcnt_q      <= 1'b0;
			ent_q       <= '0;
			dby_p_q     <= '0;
			ser_a_q     <= '0;
			ser_b_q     <= '0;
			base_q      <= '0;
			n_q         <= '0;
			yr_q        <= '0;
			sel_q       <= '0;
			leap_q      <= 1'b0;
			r_q         <= '0;
			mo_q        <= '0;
			ry_q        <= '0;
			rm_q        <= '0;
			rd_q        <= '0;
			diff_q      <= '0;
			later_q     <= 1'b0;
			equal_q     <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_year_q  <= '0;
			out_month_q <= '0;
			out_day_q   <= '0;
			out_diff_q  <= '0;
			out_later_q <= 1'b0;
			out_equal_q <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			// output register fills from the sequencer, empties on a taken word
			if ((st_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (avail) begin
						ent_q   <= pop_data;
						ry_q    <= pop_data.fy;
						rm_q    <= pop_data.fm;
						rd_q    <= pop_data.fd;
						diff_q  <= '0;
						later_q <= 1'b0;
						equal_q <= 1'b0;
						err_q   <= pop_data.err;
						if (pop_data.err) begin
							st_q <= ST_OUT;
						end else begin
							dby_p_q <= YW'(pop_data.fy) - YW'(1);
							wcnt_q  <= 1'b0;
							ret_q   <= ST_SERA;
							st_q    <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					wcnt_q <= ~wcnt_q;
					if (wcnt_q) begin
						st_q <= ret_q;
					end
				end
				ST_SERA: begin
					ser_a_q <= ser_f;
					if (ent_q.cmd == gdod_pkg::CMD_DIFF) begin
						dby_p_q <= YW'(ent_q.sy) - YW'(1);
						wcnt_q  <= 1'b0;
						ret_q   <= ST_SERB;
						st_q    <= ST_WAIT;
					end else begin
						st_q <= ST_ADD;
					end
				end
				ST_SERB: begin
					ser_b_q <= ser_s;
					st_q    <= ST_DIFF;
				end
				ST_DIFF: begin
					later_q <= (diff_w > $signed(SW'(0)));
					equal_q <= (diff_w == '0);
					if (diff_w > DIFF_HI) begin
						diff_q <= gdod_pkg::DIFF_W'(DIFF_HI);
					end else if (diff_w < DIFF_LO) begin
						diff_q <= gdod_pkg::DIFF_W'(DIFF_LO);
					end else begin
						diff_q <= gdod_pkg::DIFF_W'(diff_w);
					end
					st_q <= ST_OUT;
				end
				ST_ADD: begin
					n_q  <= $signed(SW'(ser_a_q)) + SW'(ent_q.off);
					st_q <= ST_RNG;
				end
				ST_RNG: begin
					// shifted date before the first day or past the last year
					if (n_q[SW-1] || (n_q >= $signed(SW'(DBY_END)))) begin
						err_q <= 1'b1;
						st_q  <= ST_OUT;
					end else begin
						yr_q    <= '0;
						base_q  <= '0;
						sel_q   <= SELW'(YW - 1);
						dby_p_q <= (YW'(1) << (YW - 1)) - YW'(1);
						wcnt_q  <= 1'b0;
						ret_q   <= ST_BCMP;
						st_q    <= ST_WAIT;
					end
				end
				ST_BCMP: begin
					yr_q <= new_yr;
					if (take) begin
						base_q <= dby_s2;
					end
					wcnt_q <= 1'b0;
					st_q   <= ST_WAIT;
					if (sel_q == '0) begin
						// feed the year itself to get year / 100
						dby_p_q <= new_yr;
						ret_q   <= ST_LEAP;
					end else begin
						sel_q   <= sel_q - SELW'(1);
						dby_p_q <= next_cand - YW'(1);
						ret_q   <= ST_BCMP;
					end
				end
				ST_LEAP: begin
					leap_q <= gdod_pkg::is_leap(gdod_pkg::YEAR_MAX_W'(yr_q),
						gdod_pkg::YEAR_MAX_W'(q100_s1));
					r_q    <= gdod_pkg::CUM_W'(n_q[DW-1:0] - base_q);
					mo_q   <= 4'd1;
					st_q   <= ST_MW;
				end
				ST_MW: begin
					// walk the months of the found year
					if ((mo_q < 4'(gdod_pkg::MONTHS)) && (r_q >= gdod_pkg::CUM_W'(dim))) begin
						r_q  <= r_q - gdod_pkg::CUM_W'(dim);
						mo_q <= mo_q + 4'd1;
					end else begin
						ry_q <= gdod_pkg::YEAR_W'(yr_q);
						rm_q <= mo_q;
						rd_q <= gdod_pkg::DAY_W'(r_q + gdod_pkg::CUM_W'(1));
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_year_q  <= ry_q;
						out_month_q <= rm_q;
						out_day_q   <= rd_q;
						out_diff_q  <= diff_q;
						out_later_q <= later_q;
						out_equal_q <= equal_q;
						out_err_q   <= err_q;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = out_valid_q;
	assign result.result_year    = out_year_q;
	assign result.result_month   = out_month_q;
	assign result.result_day     = out_day_q;
	assign result.day_difference = out_diff_q;
	assign result.first_later    = out_later_q;
	assign result.dates_equal    = out_equal_q;
	assign result.error          = out_err_q;

	// a result without error always carries a real month
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_err_q) |-> ((out_month_q >= 4'd1) && (out_month_q <= 4'd12)))
		else $error("result month out of range");

	// equal dates give a zero difference and are not later
	a_equal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_equal_q) |-> ((out_diff_q == '0) && !out_later_q))
		else $error("equal dates with nonzero difference");

	// the accepted year start never passes the target day
	a_search_base: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_BCMP) |-> (base_q <= n_q[DW-1:0]))
		else $error("year search overshoot");

	// the day remainder in the month walk stays within a year
	a_day_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MW) |-> (r_q < 9'd366))
		else $error("day remainder beyond a year");

endmodule

`default_nettype wire

### rtl/core/gregorian_date_offset_and_difference_top.sv
`default_nettype none

// Gregorian date unit: shifts a date by a signed day offset (command 0) or gives
// the signed day count first minus second (command 1), with later/equal flags.
// Channels: item takes one command word on valid and ready; result gives one
// result word per command word, in order, on valid and ready.
// The front takes a word, checks its first date (both dates for a difference)
// and places it in a two-word queue, taking the next word while the back works.
// The back turns dates into day numbers through a two-stage multiply unit and,
// for a shift, finds the year by a bitwise search over Y = clog2(LAST_YEAR + 1)
// bits, then walks the months one per cycle; that search sets the shift rate.
// A finished result waits in an output register; while the receiver stalls the
// back holds its next result and the queue keeps taking words until full.
// Reset clears all control state and the queue; no clearing pass is needed.
module gregorian_date_offset_and_difference_top #(
	parameter int LAST_YEAR   = gdod_pkg::LAST_YEAR_DEF,
	parameter int OFFSET_BITS = gdod_pkg::OFFSET_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	gdod_item_if.sink      item,
	gdod_result_if.source  result
);

	gdod_pkg::entry_t push_data, pop_data;
	logic             push, full, pop, avail;

	// accept and check
	gdod_front #(
		.LAST_YEAR (LAST_YEAR)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push_data (push_data),
		.push      (push),
		.full      (full)
	);

	// decoupling queue
	gdod_queue #(
		.DEPTH (gdod_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.avail     (avail)
	);

	// day arithmetic
	gdod_back #(
		.LAST_YEAR   (LAST_YEAR),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.pop_data (pop_data),
		.pop      (pop),
		.result   (result)
	);

endmodule

`default_nettype wire
